@@ hdl/trail_bit_histogram_capacity_top_defines.svh @@
// assertion helpers shared by the rtl
`ifndef TRAIL_BIT_HISTOGRAM_CAPACITY_TOP_DEFINES_SVH
`define TRAIL_BIT_HISTOGRAM_CAPACITY_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CHK_SAME(lbl, ante, cons)
`define CHK_NEXT(lbl, ante, cons)
`endif

`endif

@@ hdl/tbhc_pkg.sv @@
package tbhc_pkg;

  localparam int BLOCK_BITS  = 16;
  localparam int TRAIL_BITS  = 4;
  localparam int MAX_SAMPLES = 65536;
  localparam int POS_W       = 4;
  localparam int REG_W       = 16;
  localparam int IDX_W       = 2 * TRAIL_BITS;
  localparam int BINS        = 1 << IDX_W;
  localparam int CNT_W       = 17;
  localparam int NUM_W       = 57;
  localparam int DIFF_W      = CNT_W + IDX_W;
  localparam int SQ_W        = 2 * DIFF_W;
  localparam int DRAIN_CYC   = 3;
  localparam int DRAIN_W     = 2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INC,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             sample;
    logic             drop;
    logic             inc_write;
    logic             walk_read;
    logic             clear_write;
    logic             finish;
    logic [IDX_W-1:0] bin;
  } cmd_t;

  typedef struct packed {
    logic full;
  } status_t;

  function automatic logic [TRAIL_BITS-1:0] gather(input logic [BLOCK_BITS-1:0] st,
                                                   input logic [REG_W-1:0] positions);
    logic [TRAIL_BITS-1:0] value;
    logic [POS_W-1:0]      pos;
    value = '0;
    for (int j = 0; j < TRAIL_BITS; j++) begin
      pos = positions[POS_W*j +: POS_W];
      if (32'(pos) < BLOCK_BITS) begin
        value[j] = st[pos];
      end
    end
    return value;
  endfunction

endpackage

@@ hdl/tbhc_ctrl.sv @@
`include "trail_bit_histogram_capacity_top_defines.svh"

module tbhc_ctrl
  import tbhc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    last,
  input  status_t status,
  output logic    busy,
  output logic    done,
  output cmd_t    cmd
);

  state_t             state, state_next;
  logic [IDX_W-1:0]   bin;
  logic [DRAIN_W-1:0] drain;
  logic               last_q;
  logic               accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      bin    <= '0;
      drain  <= '0;
      last_q <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR || state == ST_WALK) begin
        bin <= bin + 1'b1;
      end
      if (state == ST_DRAIN) begin
        drain <= drain + 1'b1;
      end else begin
        drain <= '0;
      end
      if (accept) begin
        last_q <= last;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (bin == IDX_W'(BINS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (!status.full) state_next = ST_INC;
          else if (last)    state_next = ST_WALK;
        end
      end
      ST_INC: begin
        state_next = last_q ? ST_WALK : ST_IDLE;
      end
      ST_WALK: begin
        if (bin == IDX_W'(BINS - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain == DRAIN_W'(DRAIN_CYC - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy            = 1'b1;
    done            = 1'b0;
    cmd             = '0;
    cmd.bin         = bin;
    case (state)
      ST_CLEAR: begin
        cmd.clear_write = 1'b1;
      end
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.sample = start && !status.full;
        cmd.drop   = start && status.full;
      end
      ST_INC: begin
        cmd.inc_write = 1'b1;
      end
      ST_WALK: begin
        cmd.walk_read = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_DONE: begin
        done       = 1'b1;
        cmd.finish = 1'b1;
      end
      default: begin
      end
    endcase
  end

  `CHK_NEXT(a_sample_writes_back, accept && !status.full, cmd.inc_write)
  `CHK_NEXT(a_done_returns_idle, done, !busy)
  `CHK_NEXT(a_walk_ends_in_drain, state == ST_WALK && bin == IDX_W'(BINS - 1),
            state == ST_DRAIN)

endmodule

@@ hdl/tbhc_datapath.sv @@
`include "trail_bit_histogram_capacity_top_defines.svh"

module tbhc_datapath
  import tbhc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  logic [REG_W-1:0]      input_positions,
  input  logic [REG_W-1:0]      output_positions,
  input  logic [BLOCK_BITS-1:0] initial_state,
  input  logic [BLOCK_BITS-1:0] round_state,
  output status_t               status,
  output logic [NUM_W-1:0]      capacity_numerator,
  output logic [CNT_W-1:0]      sample_count,
  output logic                  overflow
);

  logic [CNT_W-1:0]  mem [BINS];
  logic [CNT_W-1:0]  rd_data;
  logic [IDX_W-1:0]  idx, idx_q, rd_addr, wr_addr;
  logic [CNT_W-1:0]  samples_seen;
  logic              dropped_flag;
  logic              v_rd, v_diff, v_sq;
  logic [DIFF_W-1:0] scaled, total, diff;
  logic [SQ_W-1:0]   sq;
  logic [NUM_W-1:0]  sum;

  assign idx = {gather(initial_state, input_positions),
                gather(round_state, output_positions)};
  assign rd_addr = cmd.walk_read ? cmd.bin : idx;
  assign wr_addr = cmd.inc_write ? idx_q : cmd.bin;
  assign status.full = (32'(samples_seen) >= MAX_SAMPLES);

  // histogram store
  always_ff @(posedge clk) begin
    if (cmd.sample || cmd.walk_read) begin
      rd_data <= mem[rd_addr];
    end
    if (cmd.inc_write) begin
      mem[wr_addr] <= rd_data + 1'b1;
    end else if (cmd.walk_read || cmd.clear_write) begin
      mem[wr_addr] <= '0;
    end
    if (cmd.sample) begin
      idx_q <= idx;
    end
  end

  assign scaled = {rd_data, IDX_W'(0)};
  assign total  = DIFF_W'(samples_seen);

  always_ff @(posedge clk) begin
    diff <= (scaled >= total) ? scaled - total : total - scaled;
    sq   <= diff * diff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen <= '0;
      dropped_flag <= 1'b0;
      sum          <= '0;
      v_rd         <= 1'b0;
      v_diff       <= 1'b0;
      v_sq         <= 1'b0;
    end else begin
      v_rd   <= cmd.walk_read;
      v_diff <= v_rd;
      v_sq   <= v_diff;
      if (cmd.finish) begin
        samples_seen <= '0;
        dropped_flag <= 1'b0;
        sum          <= '0;
      end else begin
        if (cmd.sample) samples_seen <= samples_seen + 1'b1;
        if (cmd.drop)   dropped_flag <= 1'b1;
        if (v_sq)       sum <= sum + NUM_W'(sq);
      end
    end
  end

  assign capacity_numerator = sum;
  assign sample_count       = samples_seen;
  assign overflow           = dropped_flag;

  `CHK_SAME(a_samples_bounded, 1'b1, 32'(samples_seen) <= MAX_SAMPLES)
  `CHK_SAME(a_one_writer, cmd.inc_write, !cmd.walk_read && !cmd.clear_write)

endmodule

@@ hdl/trail_bit_histogram_capacity_top.sv @@
// Trail bit histogram with capacity numerator. An item is taken when start is
// high and busy is low. An item that is counted is a bin read, then a
// write-back to the 256-entry bin store; an item past the sample limit only
// sets overflow. An item with last high is followed by a bin walk over all 256
// bins, one bin per cycle through the store port, a drain of the square-and-add
// pipeline, and one cycle in which done strobes with capacity_numerator,
// sample_count and overflow; the walk zeroes every bin as it reads it. The
// result is shown for that single cycle only and cannot be stalled. After reset
// busy stays high while the store is cleared; register writes are taken
// throughout.
module trail_bit_histogram_capacity_top
  import tbhc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [BLOCK_BITS-1:0] initial_state,
  input  logic [BLOCK_BITS-1:0] round_state,
  input  logic                  last,
  output logic                  done,
  output logic [NUM_W-1:0]      capacity_numerator,
  output logic [CNT_W-1:0]      sample_count,
  output logic                  overflow,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam logic REG_INPUT_POS  = 1'b0;
  localparam logic REG_OUTPUT_POS = 1'b1;

  logic [REG_W-1:0] input_positions;
  logic [REG_W-1:0] output_positions;
  logic             wr_en;
  cmd_t             cmd;
  status_t          status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_positions  <= '0;
      output_positions <= '0;
    end else if (wr_en) begin
      if (paddr[2] == REG_INPUT_POS)  input_positions  <= pwdata[REG_W-1:0];
      if (paddr[2] == REG_OUTPUT_POS) output_positions <= pwdata[REG_W-1:0];
    end
  end

  always_comb begin
    case (paddr[2])
      REG_INPUT_POS:  prdata = 32'(input_positions);
      REG_OUTPUT_POS: prdata = 32'(output_positions);
      default:        prdata = '0;
    endcase
  end

  tbhc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .last   (last),
    .status (status),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd)
  );

  tbhc_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .input_positions    (input_positions),
    .output_positions   (output_positions),
    .initial_state      (initial_state),
    .round_state        (round_state),
    .status             (status),
    .capacity_numerator (capacity_numerator),
    .sample_count       (sample_count),
    .overflow           (overflow)
  );

endmodule

@@ tb/sv/tbhc_capacity_checker.sv @@
module tbhc_capacity_checker
  import tbhc_pkg::*;
#(
  parameter logic [2:0] IN_POS_ADDR  = 3'd0,
  parameter logic [2:0] OUT_POS_ADDR = 3'd4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [BLOCK_BITS-1:0] initial_state,
  input  logic [BLOCK_BITS-1:0] round_state,
  input  logic                  last,
  input  logic                  done,
  input  logic [NUM_W-1:0]      capacity_numerator,
  input  logic [CNT_W-1:0]      sample_count,
  input  logic                  overflow,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [NUM_W-1:0] numerator;
    logic [CNT_W-1:0] count;
    logic             ovf;
  } capacity_t;

  capacity_t        capacity_q[$];
  logic [CNT_W-1:0] bin_tally[BINS];
  logic [CNT_W-1:0] samples_taken;
  logic             dropped;
  logic [REG_W-1:0] in_pos_cfg;
  logic [REG_W-1:0] out_pos_cfg;
  int               errors = 0;
  int unsigned      cycle_no = 0;

  function automatic logic [TRAIL_BITS-1:0] pick_bits(input logic [BLOCK_BITS-1:0] st,
                                                      input logic [REG_W-1:0] pos_cfg);
    logic [TRAIL_BITS-1:0] v;
    int                    p;
    v = '0;
    for (int j = 0; j < TRAIL_BITS; j++) begin
      p = int'(pos_cfg[POS_W*j +: POS_W]);
      if (p < BLOCK_BITS) begin
        v[j] = st[p];
      end
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("cycle %0d: %s: got %0d, expected %0d", cycle_no, what, got, want);
  endtask

  task automatic clear_histogram();
    foreach (bin_tally[b]) begin
      bin_tally[b] = '0;
    end
    samples_taken = '0;
    dropped       = 1'b0;
  endtask

  // histogram update, and the capacity numerator on a last item
  task automatic absorb_item(input logic [BLOCK_BITS-1:0] init_v,
                             input logic [BLOCK_BITS-1:0] rnd_v,
                             input logic last_v);
    logic [IDX_W-1:0] slot;
    logic [63:0]      sum;
    logic [63:0]      scaled;
    logic [63:0]      diff;
    logic [63:0]      total;
    capacity_t        res;
    if (samples_taken < MAX_SAMPLES) begin
      slot = {pick_bits(init_v, in_pos_cfg), pick_bits(rnd_v, out_pos_cfg)};
      bin_tally[slot] = bin_tally[slot] + 1'b1;
      samples_taken   = samples_taken + 1'b1;
    end else begin
      dropped = 1'b1;
    end
    if (last_v) begin
      sum   = '0;
      total = 64'(samples_taken);
      for (int b = 0; b < BINS; b++) begin
        scaled = 64'(bin_tally[b]) * 64'(BINS);
        diff   = (scaled >= total) ? scaled - total : total - scaled;
        sum    = sum + diff * diff;
      end
      res.numerator = sum[NUM_W-1:0];
      res.count     = samples_taken;
      res.ovf       = dropped;
      capacity_q.push_back(res);
      clear_histogram();
    end
  endtask

  always @(posedge clk) begin
    capacity_t want;
    cycle_no++;
    if (rst) begin
      clear_histogram();
      in_pos_cfg  = '0;
      out_pos_cfg = '0;
      capacity_q.delete();
    end else begin
      if (done === 1'b1) begin
        if (capacity_q.size() == 0) begin
          report_mismatch("result with none expected", 64'(capacity_numerator), 64'd0);
        end else begin
          want = capacity_q.pop_front();
          if (capacity_numerator !== want.numerator) begin
            report_mismatch("capacity_numerator", 64'(capacity_numerator),
                            64'(want.numerator));
          end
          if (sample_count !== want.count) begin
            report_mismatch("sample_count", 64'(sample_count), 64'(want.count));
          end
          if (overflow !== want.ovf) begin
            report_mismatch("overflow", 64'(overflow), 64'(want.ovf));
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == IN_POS_ADDR) begin
          in_pos_cfg = pwdata[REG_W-1:0];
        end else if (paddr == OUT_POS_ADDR) begin
          out_pos_cfg = pwdata[REG_W-1:0];
        end
      end
      if (start && !busy) begin
        absorb_item(initial_state, round_state, last);
      end
    end
    pending    <= capacity_q.size();
    fail_count <= errors;
  end

endmodule

@@ tb/sv/tb_trail_bit_histogram_capacity_top.sv @@
module tb_trail_bit_histogram_capacity_top;
  import tbhc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  IN_POS_ADDR  = 3'd0;
  localparam logic [2:0]  OUT_POS_ADDR = 3'd4;
  localparam int          MAX_GAP      = 18;
  localparam int          SETTLE_CYC   = 8;
  localparam int          TAIL_CYC     = BINS + 64;
  localparam int          PHASES       = 7;
  localparam int          PHASE_ITEMS  = 200;
  localparam int unsigned LIMIT_CYC    = 3_000_000;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [BLOCK_BITS-1:0] initial_state;
  logic [BLOCK_BITS-1:0] round_state;
  logic                  last;
  logic                  done;
  logic [NUM_W-1:0]      capacity_numerator;
  logic [CNT_W-1:0]      sample_count;
  logic                  overflow;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending;
  int unsigned           cycle_count = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  trail_bit_histogram_capacity_top u_top (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .initial_state      (initial_state),
    .round_state        (round_state),
    .last               (last),
    .done               (done),
    .capacity_numerator (capacity_numerator),
    .sample_count       (sample_count),
    .overflow           (overflow),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  tbhc_capacity_checker #(
    .IN_POS_ADDR  (IN_POS_ADDR),
    .OUT_POS_ADDR (OUT_POS_ADDR)
  ) u_checker (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .initial_state      (initial_state),
    .round_state        (round_state),
    .last               (last),
    .done               (done),
    .capacity_numerator (capacity_numerator),
    .sample_count       (sample_count),
    .overflow           (overflow),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .pready             (pready),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYC) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [REG_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_positions(input logic [REG_W-1:0] in_pos, input logic [REG_W-1:0] out_pos);
    apb_write(IN_POS_ADDR, in_pos);
    apb_write(OUT_POS_ADDR, out_pos);
  endtask

  // start stays high across back-to-back items
  task automatic send_item(input logic [BLOCK_BITS-1:0] init_v,
                           input logic [BLOCK_BITS-1:0] rnd_v,
                           input logic last_v, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    initial_state <= init_v;
    round_state   <= rnd_v;
    last          <= last_v;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic quiesce();
    drain_results();
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  initial begin
    logic [BLOCK_BITS-1:0] init_v;
    logic [BLOCK_BITS-1:0] rnd_v;
    logic                  last_v;
    logic                  steady;
    int                    gap;
    rst           <= 1'b1;
    start         <= 1'b0;
    initial_state <= '0;
    round_state   <= '0;
    last          <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset positions: every trail bit from bit 0
    send_item(16'h0000, 16'h0000, 1'b0, 0);
    send_item(16'hFFFF, 16'hFFFF, 1'b1, 0);
    quiesce();

    set_positions(16'hFFFF, 16'hFFFF);
    send_item(16'h8000, 16'h0000, 1'b0, 0);
    send_item(16'h0000, 16'h8000, 1'b0, 3);
    send_item(16'hFFFF, 16'hFFFF, 1'b0, 0);
    send_item(16'h7FFF, 16'h7FFF, 1'b1, 1);
    quiesce();

    // distinct positions: a single-sample run, then a three-item run
    set_positions(16'h3210, 16'hFEDC);
    send_item(16'h1234, 16'hABCD, 1'b1, 0);
    quiesce();
    send_item(16'h000F, 16'hF000, 1'b0, 0);
    send_item(16'h0005, 16'hA000, 1'b0, 2);
    send_item(16'h000A, 16'h5000, 1'b1, 0);
    quiesce();

    // fill to the sample limit in one bin, then drop items incl. the last
    set_positions(16'hC840, 16'h1357);
    for (int i = 0; i < MAX_SAMPLES; i++) begin
      send_item(16'hA5C3, 16'h3C5A, 1'b0, 0);
    end
    send_item(16'($urandom), 16'($urandom), 1'b0, 0);
    send_item(16'($urandom), 16'($urandom), 1'b0, 1);
    send_item(16'($urandom), 16'($urandom), 1'b1, 0);
    quiesce();

    init_v = 16'($urandom);
    rnd_v  = 16'($urandom);
    steady = 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_positions(16'h0000, 16'hFFFF);
        1: set_positions(16'hFFFF, 16'h0000);
        default: set_positions(16'($urandom), 16'($urandom));
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) begin
          steady = ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 2) != 0) begin
          init_v = 16'($urandom);
        end
        if ($urandom_range(0, 2) != 0) begin
          rnd_v = 16'($urandom);
        end
        last_v = (k == PHASE_ITEMS - 1) || ($urandom_range(0, 11) == 0);
        gap    = steady ? 0 : $urandom_range(0, MAX_GAP);
        send_item(init_v, rnd_v, last_v, gap);
        if (last_v && k != PHASE_ITEMS - 1 && $urandom_range(0, 4) == 0) begin
          drain_results();
        end
      end
      quiesce();
    end

    repeat (TAIL_CYC) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/tbhc_pkg.sv
hdl/tbhc_ctrl.sv
hdl/tbhc_datapath.sv
hdl/trail_bit_histogram_capacity_top.sv
tb/sv/tbhc_capacity_checker.sv
tb/sv/tb_trail_bit_histogram_capacity_top.sv
